// ===== rtl/tlv8sp_pkg.sv =====
`default_nettype none
package tlv8sp_pkg;

	localparam int LENGTH_BITS = 16;
	localparam int FIFO_DEPTH  = 4;
	localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
	localparam int LVL_BITS    = $clog2(FIFO_DEPTH + 1);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	typedef logic [LENGTH_BITS-1:0] len_t;

	typedef enum logic [2:0] {
		PH_TYPE  = 3'b001,
		PH_LEN   = 3'b010,
		PH_VALUE = 3'b100
	} phase_t;

	typedef enum logic {
		RK_VALUE = 1'b0,
		RK_END   = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [7:0]  item_type;
		logic [7:0]  value_byte;
		logic [15:0] value_offset;
		logic [15:0] item_length;
		logic        truncated;
		logic        body_done;
	} res_t;

	// length counter folded into the 16-bit output fields
	function automatic logic [15:0] to_len16(input len_t v);
		logic [31:0] wide;
		wide = 32'(v);
		return wide[15:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/tlv8sp_res_fifo.sv =====
`default_nettype none
module tlv8sp_res_fifo (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  [1:0]                   push_n,
	input  tlv8sp_pkg::res_t             wr0,
	input  tlv8sp_pkg::res_t             wr1,
	input  wire                          pop,
	output tlv8sp_pkg::res_t             rd,
	output logic                         rd_valid,
	output logic [tlv8sp_pkg::LVL_BITS-1:0] level
);
	import tlv8sp_pkg::*;

	res_t                mem [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wp_q;
	logic [PTR_BITS-1:0] rp_q;
	logic [LVL_BITS-1:0] lvl_q;
	logic [PTR_BITS-1:0] wp_inc;

	assign wp_inc = wp_q + PTR_BITS'(1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wp_q] <= wr0;
		end
		if (push_n == 2'd2) begin
			mem[wp_inc] <= wr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			lvl_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_BITS'(push_n);
			rp_q  <= rp_q + PTR_BITS'(pop);
			lvl_q <= lvl_q + LVL_BITS'(push_n) - LVL_BITS'(pop);
		end
	end

	assign rd       = mem[rp_q];
	assign rd_valid = (lvl_q != '0);
	assign level    = lvl_q;

endmodule
`default_nettype wire

// ===== rtl/tlv8_stream_parser_top.sv =====
// path: an accepted beat is registered, then its results are written into the result queue
// throughput: one input beat per cycle while the queue has room for two results; results
// leave at one per cycle while out_stall is low, so input stalls while the queue holds more than two
// a four-entry result queue sits between the parser and the output channel
// reset: arst_n clears the parser to expect a type byte with no item open
`default_nettype none
module tlv8_stream_parser_top (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] data_byte,
	input  wire        end_of_body,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       result_kind,
	output logic [7:0] item_type,
	output logic [7:0] value_byte,
	output logic [15:0] value_offset,
	output logic [15:0] item_length,
	output logic       truncated,
	output logic       body_done
);
	import tlv8sp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;

	phase_t     phase_q;
	logic [7:0] cur_type_q;
	logic       item_open_q;
	logic [7:0] remain_q;
	len_t       len_q;

	phase_t     phase_d;
	logic [7:0] cur_type_d;
	logic       item_open_d;
	logic [7:0] remain_d;
	len_t       len_d;

	logic       pre_v;
	res_t       pre_r;
	res_t       end_r;
	logic       trunc;
	logic [1:0] push_n;
	res_t       wr0;
	res_t       wr1;
	res_t       head;
	logic       head_v;
	logic [LVL_BITS-1:0] level;
	logic       advance;
	logic       pop;

	assign advance  = valid_s1 && (level <= LVL_BITS'(FIFO_DEPTH - 2));
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			eob_s1  <= end_of_body;
		end
	end

	// one parser step on the registered beat
	always_comb begin
		phase_d     = phase_q;
		cur_type_d  = cur_type_q;
		item_open_d = item_open_q;
		remain_d    = remain_q;
		len_d       = len_q;
		pre_v       = 1'b0;
		pre_r       = '0;
		trunc       = 1'b0;
		end_r       = '0;

		unique case (phase_q)
			PH_LEN: begin
				remain_d = byte_s1;
				if (byte_s1 == 8'd0) begin
					phase_d = PH_TYPE;
				end else begin
					phase_d = PH_VALUE;
					trunc   = 1'b1;
				end
			end
			PH_VALUE: begin
				pre_v              = 1'b1;
				pre_r.result_kind  = RK_VALUE;
				pre_r.item_type    = cur_type_q;
				pre_r.value_byte   = byte_s1;
				pre_r.value_offset = to_len16(len_q);
				if (len_q != LEN_MAX) begin
					len_d = len_q + LENGTH_BITS'(1);
				end
				remain_d = remain_q - 8'd1;
				if (remain_q == 8'd1) begin
					phase_d = PH_TYPE;
				end else begin
					trunc = 1'b1;
				end
			end
			default: begin
				// unused phase codes behave as the type phase
				if (item_open_q && (byte_s1 != cur_type_q)) begin
					pre_v             = 1'b1;
					pre_r.result_kind = RK_END;
					pre_r.item_type   = cur_type_q;
					pre_r.item_length = to_len16(len_q);
				end
				if (!item_open_q || (byte_s1 != cur_type_q)) begin
					cur_type_d  = byte_s1;
					len_d       = '0;
					item_open_d = 1'b1;
				end
				phase_d = PH_LEN;
				trunc   = 1'b1;
			end
		endcase

		end_r.result_kind = RK_END;
		end_r.item_type   = cur_type_d;
		end_r.item_length = to_len16(len_d);
		end_r.truncated   = trunc;
		end_r.body_done   = 1'b1;
	end

	always_comb begin
		push_n = 2'd0;
		wr0    = pre_r;
		wr1    = end_r;
		if (advance) begin
			if (pre_v && eob_s1) begin
				push_n = 2'd2;
			end else if (pre_v) begin
				push_n = 2'd1;
			end else if (eob_s1) begin
				push_n = 2'd1;
				wr0    = end_r;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TYPE;
			cur_type_q  <= '0;
			item_open_q <= 1'b0;
			remain_q    <= '0;
			len_q       <= '0;
		end else if (advance) begin
			if (eob_s1) begin
				phase_q     <= PH_TYPE;
				cur_type_q  <= '0;
				item_open_q <= 1'b0;
				remain_q    <= '0;
				len_q       <= '0;
			end else begin
				phase_q     <= phase_d;
				cur_type_q  <= cur_type_d;
				item_open_q <= item_open_d;
				remain_q    <= remain_d;
				len_q       <= len_d;
			end
		end
	end

	assign pop = head_v && !out_stall;

	tlv8sp_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.wr0      (wr0),
		.wr1      (wr1),
		.pop      (pop),
		.rd       (head),
		.rd_valid (head_v),
		.level    (level)
	);

	assign out_valid    = head_v;
	assign result_kind  = head.result_kind;
	assign item_type    = head.item_type;
	assign value_byte   = head.value_byte;
	assign value_offset = head.value_offset;
	assign item_length  = head.item_length;
	assign truncated    = head.truncated;
	assign body_done    = head.body_done;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (level <= LVL_BITS'(FIFO_DEPTH - 2)))
		else $error("result queue would overflow");

	a_body_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eob_s1) |=> (phase_q == PH_TYPE) && !item_open_q)
		else $error("parser not back to idle after body end");

	a_value_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_kind == RK_VALUE)) |->
		(!truncated && !body_done && (item_length == 16'd0)))
		else $error("value beat carries end fields");

	a_value_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (phase_q == PH_VALUE)) |-> item_open_q)
		else $error("value byte with no open item");

endmodule
`default_nettype wire
